// ===== rtl/core/pwq_pkg.sv =====
package pwq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int TASK_W      = 4;
	localparam int PRIO_W      = 8;
	localparam int NUM_TASKS   = 1 << TASK_W;
	localparam int COUNT_W     = 5;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PUT,
		ST_HEAD_RD,
		ST_HEAD_WAIT
	} pwq_state_t;

endpackage

// ===== rtl/core/priority_wait_queue_core.sv =====
// Channel   Ports                                                     Handshake
// command   action, task_id, task_valid, priority_req                 start && !busy
// result    ok, head_valid, head_task, head_priority, entry_count     done (one cycle)
//
// One transaction at a time. The slot store is a memory with one write and one
// registered read port; the walk touches one slot per cycle, and a command that
// fails early skips the walk and goes straight to the head read.
// Reset clears the count and the membership bits; slot contents need no clearing.
// The result cannot be stalled: done is high for one cycle and busy drops with it.
module priority_wait_queue_core
	import pwq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               action,
	input  logic [TASK_W-1:0]  task_id,
	input  logic               task_valid,
	input  logic [PRIO_W-1:0]  priority_req,
	output logic               done,
	output logic               ok,
	output logic               head_valid,
	output logic [TASK_W-1:0]  head_task,
	output logic [PRIO_W-1:0]  head_priority,
	output logic [COUNT_W-1:0] entry_count
);

	logic [TASK_W-1:0] mem_task [QUEUE_DEPTH];
	logic [PRIO_W-1:0] mem_prio [QUEUE_DEPTH];

	pwq_state_t state_q, state_d;

	logic                 action_q;
	logic [TASK_W-1:0]    tid_q;
	logic [PRIO_W-1:0]    prio_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [NUM_TASKS-1:0] member_q;
	logic [IDX_W-1:0]     ptr_q;
	logic                 issue_q;
	logic                 found_q;
	logic                 ok_q;

	logic                 vld_s1;
	logic [IDX_W-1:0]     addr_s1;
	logic [TASK_W-1:0]    rd_task_s1;
	logic [PRIO_W-1:0]    rd_prio_s1;

	logic                 done_q;
	logic                 head_valid_q;
	logic [TASK_W-1:0]    head_task_q;
	logic [PRIO_W-1:0]    head_prio_q;

	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [TASK_W-1:0]    mem_wtask;
	logic [PRIO_W-1:0]    mem_wprio;
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic                 ins_done;
	logic                 rem_done;
	logic                 rem_hit;

	logic                 accept;
	logic                 cmd_fail;
	logic [IDX_W-1:0]     last_idx;

	assign accept   = start && (state_q == ST_IDLE);
	assign last_idx = IDX_W'(cnt_q - CNT_W'(1));
	assign cmd_fail = !task_valid
		|| ((action == ACT_INSERT) && (member_q[task_id] || (cnt_q == CNT_W'(QUEUE_DEPTH))))
		|| ((action == ACT_REMOVE) && !member_q[task_id]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wtask = tid_q;
		mem_wprio = prio_q;
		rd_en     = 1'b0;
		rd_addr   = ptr_q;
		ins_done  = 1'b0;
		rem_done  = 1'b0;
		rem_hit   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (cmd_fail) begin
						state_d = ST_HEAD_RD;
					end else if ((action == ACT_INSERT) && (cnt_q == '0)) begin
						state_d = ST_PUT;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				rd_en = issue_q;
				if (vld_s1) begin
					if (action_q == ACT_INSERT) begin
						// walk from the tail, shift larger entries up by one
						mem_we = 1'b1;
						mem_waddr = addr_s1 + IDX_W'(1);
						if (rd_prio_s1 > prio_q) begin
							mem_wtask = rd_task_s1;
							mem_wprio = rd_prio_s1;
							if (addr_s1 == '0) begin
								state_d = ST_PUT;
							end
						end else begin
							ins_done = 1'b1;
							state_d  = ST_HEAD_RD;
						end
					end else begin
						// close the gap behind the removed entry
						if (found_q) begin
							mem_we    = 1'b1;
							mem_waddr = addr_s1 - IDX_W'(1);
							mem_wtask = rd_task_s1;
							mem_wprio = rd_prio_s1;
						end else if (rd_task_s1 == tid_q) begin
							rem_hit = 1'b1;
						end
						if (addr_s1 == last_idx) begin
							rem_done = 1'b1;
							state_d  = ST_HEAD_RD;
						end
					end
				end
			end
			ST_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				ins_done  = 1'b1;
				state_d   = ST_HEAD_RD;
			end
			ST_HEAD_RD: begin
				rd_en   = 1'b1;
				rd_addr = '0;
				state_d = ST_HEAD_WAIT;
			end
			ST_HEAD_WAIT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_task[mem_waddr] <= mem_wtask;
			mem_prio[mem_waddr] <= mem_wprio;
		end
		if (rd_en) begin
			rd_task_s1 <= mem_task[rd_addr];
			rd_prio_s1 <= mem_prio[rd_addr];
		end
		addr_s1 <= rd_addr;
		if (accept) begin
			action_q <= action;
			tid_q    <= task_id;
			prio_q   <= priority_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			member_q     <= '0;
			ptr_q        <= '0;
			issue_q      <= 1'b0;
			found_q      <= 1'b0;
			ok_q         <= 1'b0;
			vld_s1       <= 1'b0;
			done_q       <= 1'b0;
			head_valid_q <= 1'b0;
			head_task_q  <= '0;
			head_prio_q  <= '0;
		end else begin
			vld_s1 <= rd_en && (state_d == ST_SCAN);
			done_q <= 1'b0;
			if (accept) begin
				ok_q    <= 1'b0;
				found_q <= 1'b0;
				issue_q <= 1'b1;
				ptr_q   <= (action == ACT_INSERT) ? last_idx : '0;
			end else if (rd_en && (state_q == ST_SCAN)) begin
				// advance the read pointer, stop at the far end
				if (action_q == ACT_INSERT) begin
					if (ptr_q == '0) begin
						issue_q <= 1'b0;
					end else begin
						ptr_q <= ptr_q - IDX_W'(1);
					end
				end else begin
					if (ptr_q == last_idx) begin
						issue_q <= 1'b0;
					end else begin
						ptr_q <= ptr_q + IDX_W'(1);
					end
				end
			end
			if (rem_hit) begin
				found_q <= 1'b1;
			end
			if (ins_done) begin
				cnt_q           <= cnt_q + CNT_W'(1);
				member_q[tid_q] <= 1'b1;
				ok_q            <= 1'b1;
			end
			if (rem_done) begin
				member_q[tid_q] <= 1'b0;
				if (found_q || rem_hit) begin
					cnt_q <= cnt_q - CNT_W'(1);
					ok_q  <= 1'b1;
				end
			end
			if (state_q == ST_HEAD_WAIT) begin
				done_q       <= 1'b1;
				head_valid_q <= (cnt_q != '0);
				head_task_q  <= (cnt_q != '0) ? rd_task_s1 : '0;
				head_prio_q  <= (cnt_q != '0) ? rd_prio_s1 : '0;
			end
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign ok            = ok_q;
	assign head_valid    = head_valid_q;
	assign head_task     = head_task_q;
	assign head_priority = head_prio_q;
	assign entry_count   = COUNT_W'(cnt_q);

endmodule
